FILE: rtl/twcp_pkg.sv
// ----------------------------------------------------------------------------
// twcp_pkg
// Shared types, codes and frame helpers of the tape word/frame packer.
// ----------------------------------------------------------------------------
package twcp_pkg;

  localparam int unsigned WordW  = 36;
  localparam int unsigned FrameW = 8;
  localparam int unsigned IdxW   = 3;

  // Function codes carried by an input beat.
  typedef enum logic [2:0] {
    FUNC_READ    = 3'd0,
    FUNC_COMPARE = 3'd1,
    FUNC_WRITE   = 3'd2,
    FUNC_CPU_IN  = 3'd3,
    FUNC_CPU_OUT = 3'd4,
    FUNC_STOP    = 3'd5,
    FUNC_START   = 3'd6
  } func_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SEVEN_TRACK = 2'd0,
    CFG_FIVE_FRAME  = 2'd1,
    CFG_PAR_ODD     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic seven_track;
    logic five_frame;
    logic par_odd;
  } cfg_t;

  typedef struct packed {
    logic word_req;
    logic word_late;
    logic parity_error;
    logic compare_error;
    logic length_error;
  } status_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [FrameW-1:0] tape_frame;
    logic [WordW-1:0]  cpu_word;
    logic              want_data;
  } in_beat_t;

  typedef struct packed {
    logic [FrameW-1:0] frame_out;
    logic              frame_valid;
    logic [WordW-1:0]  word_out;
    status_t           status;
    logic              record_end;
    logic [IdxW-1:0]   frame_count;
  } out_beat_t;

  // Parity bit for six data bits: even parity unless odd is selected.
  function automatic logic parity6(logic [5:0] data, logic odd);
    return odd ^ (^data);
  endfunction

  // Frame at position idx of word w; positions past the word give zero.
  function automatic logic [FrameW-1:0] frame_of(logic [WordW-1:0] w,
                                                 logic [IdxW-1:0] idx,
                                                 logic seven);
    logic [FrameW-1:0] f;
    f = '0;
    if (seven) begin
      case (idx)
        3'd0:    f = {2'b00, w[35:30]};
        3'd1:    f = {2'b00, w[29:24]};
        3'd2:    f = {2'b00, w[23:18]};
        3'd3:    f = {2'b00, w[17:12]};
        3'd4:    f = {2'b00, w[11:6]};
        3'd5:    f = {2'b00, w[5:0]};
        default: f = '0;
      endcase
    end else begin
      case (idx)
        3'd0:    f = w[35:28];
        3'd1:    f = w[27:20];
        3'd2:    f = w[19:12];
        3'd3:    f = w[11:4];
        3'd4:    f = {2'b00, w[5:0]};
        default: f = '0;
      endcase
    end
    return f;
  endfunction

  // Bits that frame ch contributes to the word at position idx.
  function automatic logic [WordW-1:0] place_bits(logic [FrameW-1:0] ch,
                                                  logic [IdxW-1:0] idx,
                                                  logic seven);
    logic [WordW-1:0] b;
    b = '0;
    if (seven) begin
      case (idx)
        3'd0:    b[35:30] = ch[5:0];
        3'd1:    b[29:24] = ch[5:0];
        3'd2:    b[23:18] = ch[5:0];
        3'd3:    b[17:12] = ch[5:0];
        3'd4:    b[11:6]  = ch[5:0];
        3'd5:    b[5:0]   = ch[5:0];
        default: b = '0;
      endcase
    end else begin
      case (idx)
        3'd0:    b[35:28] = ch;
        3'd1:    b[27:20] = ch;
        3'd2:    b[19:12] = ch;
        3'd3:    b[11:4]  = ch;
        3'd4:    b[5:0]   = ch[5:0];
        default: b = '0;
      endcase
    end
    return b;
  endfunction

endpackage

FILE: rtl/twcp_if.sv
// ----------------------------------------------------------------------------
// twcp_req_if / twcp_rsp_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface twcp_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  tape_frame;
  logic [35:0] cpu_word;
  logic        want_data;

  modport source (output valid, func, tape_frame, cpu_word, want_data, input ready);
  modport sink   (input valid, func, tape_frame, cpu_word, want_data, output ready);
endinterface

interface twcp_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_out;
  logic        frame_valid;
  logic [35:0] word_out;
  logic        word_req;
  logic        word_late;
  logic        parity_error;
  logic        compare_error;
  logic        length_error;
  logic        record_end;
  logic [2:0]  frame_count;

  modport source (output valid, frame_out, frame_valid, word_out, word_req,
                  word_late, parity_error, compare_error, length_error,
                  record_end, frame_count, input ready);
  modport sink   (input valid, frame_out, frame_valid, word_out, word_req,
                  word_late, parity_error, compare_error, length_error,
                  record_end, frame_count, output ready);
endinterface

FILE: rtl/twcp_in_stage.sv
// ----------------------------------------------------------------------------
// twcp_in_stage
// Input register: captures a request beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module twcp_in_stage import twcp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  twcp_req_if.sink req,
  input  logic     take_i,
  output logic     valid_o,
  output in_beat_t beat_o
);

  logic     valid_q;
  in_beat_t beat_q;

  // A new beat may enter when the register is empty or is drained this cycle.
  assign req.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req.valid && req.ready) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload capture; no reset needed.
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      beat_q <= '{func: req.func, tape_frame: req.tape_frame,
                  cpu_word: req.cpu_word, want_data: req.want_data};
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

FILE: rtl/twcp_core.sv
// ----------------------------------------------------------------------------
// twcp_core
// Configuration, buffer state and the per-beat packing/unpacking step.
// ----------------------------------------------------------------------------
module twcp_core import twcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [0:0] cfg_data_i,
  input  logic       valid_i,
  input  in_beat_t   beat_i,
  input  logic       out_free_i,
  output logic       take_o,
  output out_beat_t  result_o
);

  cfg_t            cfg_q;
  logic [WordW-1:0] asm_q, asm_d, hold_q, hold_d;
  logic [IdxW-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic            asm_full_q, asm_full_d, hold_full_q, hold_full_d;
  logic            stop_q, stop_d;
  status_t         st_q, st_d;

  logic [FrameW-1:0] fout;
  logic              fvalid, rend;
  logic [WordW-1:0]  wout;
  logic [IdxW-1:0]   nframes;
  logic [FrameW-1:0] got, exp_ch;

  assign take_o = valid_i && out_free_i;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SEVEN_TRACK: cfg_q.seven_track <= cfg_data_i[0];
        CFG_FIVE_FRAME:  cfg_q.five_frame  <= cfg_data_i[0];
        CFG_PAR_ODD:     cfg_q.par_odd     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign nframes = cfg_q.seven_track ? 3'd6 : (cfg_q.five_frame ? 3'd5 : 3'd4);

  // One step of the data path for the beat in the input register.
  always_comb begin
    asm_d       = asm_q;
    hold_d      = hold_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    asm_full_d  = asm_full_q;
    hold_full_d = hold_full_q;
    stop_d      = stop_q;
    st_d        = st_q;
    fout        = '0;
    fvalid      = 1'b0;
    rend        = 1'b0;
    wout        = '0;
    got         = '0;
    exp_ch      = '0;

    case (func_e'(beat_i.func))
      FUNC_READ: begin
        if (stop_q) begin
          st_d.length_error = 1'b1;
        end else begin
          if (cfg_q.seven_track) begin
            if (parity6(beat_i.tape_frame[5:0], cfg_q.par_odd) !=
                beat_i.tape_frame[6]) st_d.parity_error = 1'b1;
          end else if (!cfg_q.par_odd) begin
            st_d.parity_error = 1'b1;
          end
          asm_d = asm_q | place_bits(beat_i.tape_frame, idx_q, cfg_q.seven_track);
          idx_d = idx_q + 3'd1;
          cnt_d = idx_d;
          if (idx_d >= nframes) begin
            if (asm_full_q) begin
              // Previous word still waiting: overrun.
              st_d.word_late = 1'b1;
              stop_d         = 1'b1;
            end else begin
              if (!hold_full_q) begin
                hold_d        = asm_d;
                st_d.word_req = 1'b1;
                hold_full_d   = 1'b1;
              end else begin
                asm_full_d = 1'b1;
              end
              asm_d = '0;
              idx_d = '0;
            end
          end
        end
      end

      FUNC_COMPARE: begin
        if (stop_q) begin
          st_d.length_error = 1'b1;
        end else if (!asm_full_q && !hold_full_q) begin
          st_d.word_late = 1'b1;
          stop_d         = 1'b1;
        end else begin
          if (!asm_full_q) begin
            asm_d         = hold_q;
            st_d.word_req = 1'b1;
            hold_full_d   = 1'b0;
            asm_full_d    = 1'b1;
            idx_d         = '0;
          end
          if (cfg_q.seven_track) begin
            if (parity6(beat_i.tape_frame[5:0], cfg_q.par_odd) !=
                beat_i.tape_frame[6]) st_d.parity_error = 1'b1;
            got = {2'b00, beat_i.tape_frame[5:0]};
          end else begin
            if (!cfg_q.par_odd) st_d.parity_error = 1'b1;
            got = beat_i.tape_frame;
          end
          exp_ch = frame_of(asm_d, idx_d, cfg_q.seven_track);
          if (got != exp_ch) begin
            st_d.compare_error = 1'b1;
            stop_d             = 1'b1;
            cnt_d              = idx_d;
          end else begin
            idx_d = idx_d + 3'd1;
            if (idx_d >= nframes) begin
              idx_d      = '0;
              asm_full_d = 1'b0;
            end
            cnt_d = idx_d;
          end
        end
      end

      FUNC_WRITE: begin
        if (!asm_full_q) begin
          if (!hold_full_q) begin
            if (!stop_q) begin
              st_d.word_late = 1'b1;
              stop_d         = 1'b1;
            end
          end else begin
            asm_d = hold_q;
            if (!stop_q) st_d.word_req = 1'b1;
            hold_full_d = 1'b0;
            asm_full_d  = 1'b1;
            idx_d       = '0;
          end
        end
        if (asm_full_d) begin
          fout = frame_of(asm_d, idx_d, cfg_q.seven_track);
          if (cfg_q.seven_track) fout[6] = parity6(fout[5:0], cfg_q.par_odd);
          fvalid = 1'b1;
          idx_d  = idx_d + 3'd1;
          if (idx_d >= nframes) begin
            idx_d      = '0;
            asm_full_d = 1'b0;
          end
          cnt_d = idx_d;
        end
        rend = stop_d && !asm_full_d && !hold_full_d;
      end

      FUNC_CPU_IN: begin
        hold_d        = beat_i.cpu_word;
        st_d.word_req = 1'b0;
        hold_full_d   = 1'b1;
      end

      FUNC_CPU_OUT: begin
        wout          = hold_q;
        hold_full_d   = 1'b0;
        st_d.word_req = 1'b0;
        if (asm_full_q) begin
          hold_d        = asm_q;
          asm_d         = '0;
          asm_full_d    = 1'b0;
          hold_full_d   = 1'b1;
          st_d.word_req = 1'b1;
        end
      end

      FUNC_STOP: begin
        stop_d = 1'b1;
      end

      FUNC_START: begin
        st_d          = '0;
        st_d.word_req = beat_i.want_data;
        cnt_d         = '0;
        idx_d         = '0;
        asm_d         = '0;
        hold_full_d   = 1'b0;
        asm_full_d    = 1'b0;
        stop_d        = 1'b0;
      end

      default: ;
    endcase
  end

  // State registers advance only when the beat moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asm_q       <= '0;
      hold_q      <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      asm_full_q  <= 1'b0;
      hold_full_q <= 1'b0;
      stop_q      <= 1'b0;
      st_q        <= '0;
    end else if (take_o) begin
      asm_q       <= asm_d;
      hold_q      <= hold_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      asm_full_q  <= asm_full_d;
      hold_full_q <= hold_full_d;
      stop_q      <= stop_d;
      st_q        <= st_d;
    end
  end

  assign result_o = '{frame_out: fout, frame_valid: fvalid, word_out: wout,
                      status: st_d, record_end: rend, frame_count: cnt_d};

endmodule

FILE: rtl/twcp_out_stage.sv
// ----------------------------------------------------------------------------
// twcp_out_stage
// Result register: holds a result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module twcp_out_stage import twcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  out_beat_t  result_i,
  output logic       free_o,
  twcp_rsp_if.source rsp
);

  logic      valid_q;
  out_beat_t beat_q;

  // Room for a new result when empty or when the held one leaves now.
  assign free_o = !valid_q || rsp.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (rsp.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      beat_q <= result_i;
    end
  end

  assign rsp.valid         = valid_q;
  assign rsp.frame_out     = beat_q.frame_out;
  assign rsp.frame_valid   = beat_q.frame_valid;
  assign rsp.word_out      = beat_q.word_out;
  assign rsp.word_req      = beat_q.status.word_req;
  assign rsp.word_late     = beat_q.status.word_late;
  assign rsp.parity_error  = beat_q.status.parity_error;
  assign rsp.compare_error = beat_q.status.compare_error;
  assign rsp.length_error  = beat_q.status.length_error;
  assign rsp.record_end    = beat_q.record_end;
  assign rsp.frame_count   = beat_q.frame_count;

endmodule

FILE: rtl/tape_word_char_packer.sv
// ----------------------------------------------------------------------------
// tape_word_char_packer
// Polled data path of a 36-bit tape controller: packs frames into words,
// unpacks words into frames, compares, and reports transfer status.
//
//   channel   | dir | handshake        | payload
//   ----------+-----+------------------+-----------------------------------
//   req_i     | in  | valid / ready    | func, tape_frame, cpu_word, want_data
//   rsp_o     | out | valid / ready    | frame, word, status flags, count
//   cfg_*     | in  | cfg_we_i only    | cfg_idx_i, cfg_data_i
//
// A beat is captured in the input register and stepped by the core into the
// result register; one beat per cycle is sustained while rsp_o is not held,
// set by the single core step. Reset clears all state and configuration. When
// the result register is held, the input register fills and then req_i.ready drops.
// ----------------------------------------------------------------------------
module tape_word_char_packer import twcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [0:0] cfg_data_i,
  twcp_req_if.sink   req_i,
  twcp_rsp_if.source rsp_o
);

  logic      in_valid, take, out_free;
  in_beat_t  in_beat;
  out_beat_t result;

  twcp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_i),
    .take_i  (take),
    .valid_o (in_valid),
    .beat_o  (in_beat)
  );

  twcp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .valid_i    (in_valid),
    .beat_i     (in_beat),
    .out_free_i (out_free),
    .take_o     (take),
    .result_o   (result)
  );

  twcp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (take),
    .result_i (result),
    .free_o   (out_free),
    .rsp      (rsp_o)
  );

endmodule

FILE: rtl/twcp_checker.sv
// ----------------------------------------------------------------------------
// twcp_checker
// Port-level checks on the result channel of the packer.
// ----------------------------------------------------------------------------
module twcp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [7:0]  frame_out_i,
  input logic        frame_valid_i,
  input logic [35:0] word_out_i,
  input logic [2:0]  frame_count_i
);

  // A frame is only shown when it is marked valid.
  a_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !frame_valid_i |-> frame_out_i == 8'd0)
    else $error("frame_out set without frame_valid");

  // A word read and a tape frame never come from the same beat.
  a_word_or_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && word_out_i != 36'd0 |-> !frame_valid_i)
    else $error("word and frame in one result");

  // No word holds more than six frames.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> frame_count_i <= 3'd6)
    else $error("frame_count out of range");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(word_out_i) && $stable(frame_out_i))
    else $error("result changed while stalled");

endmodule

bind tape_word_char_packer twcp_checker u_twcp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .frame_out_i   (rsp_o.frame_out),
  .frame_valid_i (rsp_o.frame_valid),
  .word_out_i    (rsp_o.word_out),
  .frame_count_i (rsp_o.frame_count)
);
